[rtl/fpr_pkg.sv]
// fpr_pkg: shared constants, codes, beat layouts and controller/datapath types
// for the FIFO page replacement block. No dependencies.
`timescale 1ns / 1ps
package fpr_pkg;
  localparam int MAX_PAGES_D      = 64;
  localparam int RESIDENT_PAGES_D = 8;
  localparam int PAGE_BYTES_D     = 128;
  localparam int STACK_PAGES_D    = 8;
  localparam int FRAMES_D         = 32;

  localparam int CFG_AW = 5;

  typedef enum logic [1:0] {
    OP_SET_FRAME = 2'd0,
    OP_FAULT     = 2'd1,
    OP_MARK      = 2'd2,
    OP_UNUSED    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    WB_NONE = 2'd0,
    WB_EXEC = 2'd1,
    WB_SWAP = 2'd2,
    WB_RSVD = 2'd3
  } wb_t;

  typedef enum logic [1:0] {
    FILL_EXEC = 2'd0,
    FILL_SWAP = 2'd1,
    FILL_ZERO = 2'd2,
    FILL_NONE = 2'd3
  } fill_t;

  typedef enum logic [2:0] {
    SEG_NONE  = 3'd0,
    SEG_CODE  = 3'd1,
    SEG_DATA  = 3'd2,
    SEG_BSS   = 3'd3,
    SEG_STACK = 3'd4
  } seg_t;

  localparam logic [CFG_AW-1:0] REG_NUM_PAGES  = 5'd0;
  localparam logic [CFG_AW-1:0] REG_CODE_PAGES = 5'd4;
  localparam logic [CFG_AW-1:0] REG_DATA_PAGES = 5'd8;
  localparam logic [CFG_AW-1:0] REG_BSS_PAGES  = 5'd12;
  localparam logic [CFG_AW-1:0] REG_DATA_BASE  = 5'd16;
  localparam logic [CFG_AW-1:0] REG_BSS_BASE   = 5'd20;

  // input beat: one operation
  typedef struct packed {
    logic [1:0]  opcode;
    logic [12:0] fault_address;
    logic [5:0]  page_index;
    logic [4:0]  frame_number;
  } op_beat_t;

  // result beat
  typedef struct packed {
    logic [5:0] victim_page;
    logic [5:0] loaded_page;
    logic [4:0] frame_used;
    logic [6:0] page_offset;
    logic [1:0] write_back;
    logic [1:0] fill_source;
    logic       bad_address;
  } xlate_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture input beat, start decode
    logic commit;   // write tables, register result
  } fpr_cmd_t;
endpackage

[rtl/fpr_if.sv]
// fpr_stream_if: valid/ready channel carrying one payload beat.
// Payload type is a parameter; no package dependency.
`timescale 1ns / 1ps
interface fpr_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/fifo_page_replacement.sv]
// FIFO demand-paging page table, one operation per input beat, one result beat
// each. An item goes through capture and address split,
// table update with result registration, then the result is held until taken;
// the next item is accepted once the result beat leaves. The frame table sits
// in a registered-read RAM with one written flag per page, so entries never
// written read as frame zero; the status bits and the ring live in flip-flops
// that reset initialises at once, so no clearing pass is needed.
// Depends on fpr_pkg, fpr_stream_if, fpr_ctrl and fpr_dp.
`timescale 1ns / 1ps
module fifo_page_replacement #(
  parameter int MAX_PAGES      = fpr_pkg::MAX_PAGES_D,
  parameter int RESIDENT_PAGES = fpr_pkg::RESIDENT_PAGES_D,
  parameter int PAGE_BYTES     = fpr_pkg::PAGE_BYTES_D,
  parameter int STACK_PAGES    = fpr_pkg::STACK_PAGES_D,
  parameter int FRAMES         = fpr_pkg::FRAMES_D
) (
  input  logic                       clk,
  input  logic                       rst_n,
  fpr_stream_if.sink                 in_ch,
  fpr_stream_if.source               out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [fpr_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import fpr_pkg::*;

  // configuration registers
  logic [6:0]  num_pages_r, code_pages_r, data_pages_r, bss_pages_r;
  logic [12:0] data_base_r, bss_base_r;
  logic        wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_pages_r  <= 7'd64;
      code_pages_r <= '0;
      data_pages_r <= '0;
      bss_pages_r  <= '0;
      data_base_r  <= '0;
      bss_base_r   <= '0;
    end else if (wr_en) begin
      case (cfg_paddr)
        REG_NUM_PAGES:  num_pages_r  <= cfg_pwdata[6:0];
        REG_CODE_PAGES: code_pages_r <= cfg_pwdata[6:0];
        REG_DATA_PAGES: data_pages_r <= cfg_pwdata[6:0];
        REG_BSS_PAGES:  bss_pages_r  <= cfg_pwdata[6:0];
        REG_DATA_BASE:  data_base_r  <= cfg_pwdata[12:0];
        REG_BSS_BASE:   bss_base_r   <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr)
      REG_NUM_PAGES:  cfg_prdata = {25'd0, num_pages_r};
      REG_CODE_PAGES: cfg_prdata = {25'd0, code_pages_r};
      REG_DATA_PAGES: cfg_prdata = {25'd0, data_pages_r};
      REG_BSS_PAGES:  cfg_prdata = {25'd0, bss_pages_r};
      REG_DATA_BASE:  cfg_prdata = {19'd0, data_base_r};
      REG_BSS_BASE:   cfg_prdata = {19'd0, bss_base_r};
      default:        cfg_prdata = '0;
    endcase
  end

  fpr_cmd_t cmd;

  // sequence: accept, commit, hold result
  fpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  fpr_dp #(
    .MAX_PAGES      (MAX_PAGES),
    .RESIDENT_PAGES (RESIDENT_PAGES),
    .PAGE_BYTES     (PAGE_BYTES),
    .STACK_PAGES    (STACK_PAGES),
    .FRAMES         (FRAMES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .opcode         (in_ch.data.opcode),
    .fault_address  (in_ch.data.fault_address),
    .page_index     (in_ch.data.page_index),
    .frame_number   (in_ch.data.frame_number),
    .num_pages      (num_pages_r),
    .code_pages     (code_pages_r),
    .data_pages     (data_pages_r),
    .bss_pages      (bss_pages_r),
    .data_base_addr (data_base_r),
    .bss_base_addr  (bss_base_r),
    .victim_page    (out_ch.data.victim_page),
    .loaded_page    (out_ch.data.loaded_page),
    .frame_used     (out_ch.data.frame_used),
    .page_offset    (out_ch.data.page_offset),
    .write_back     (out_ch.data.write_back),
    .fill_source    (out_ch.data.fill_source),
    .bad_address    (out_ch.data.bad_address)
  );
endmodule

[rtl/fpr_ctrl.sv]
// fpr_ctrl: one-hot controller; sequences capture, commit and result hold.
// Depends on fpr_pkg.
`timescale 1ns / 1ps
module fpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fpr_pkg::fpr_cmd_t cmd
);
  import fpr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.commit = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

[rtl/fpr_dp.sv]
// fpr_dp: page table, resident ring, address split and result register,
// with the generic registered-read RAM that holds the frame table.
// Depends on fpr_pkg.
`timescale 1ns / 1ps
module fpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

module fpr_dp #(
  parameter int MAX_PAGES      = fpr_pkg::MAX_PAGES_D,
  parameter int RESIDENT_PAGES = fpr_pkg::RESIDENT_PAGES_D,
  parameter int PAGE_BYTES     = fpr_pkg::PAGE_BYTES_D,
  parameter int STACK_PAGES    = fpr_pkg::STACK_PAGES_D,
  parameter int FRAMES         = fpr_pkg::FRAMES_D
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fpr_pkg::fpr_cmd_t cmd,
  input  logic [1:0]        opcode,
  input  logic [12:0]       fault_address,
  input  logic [5:0]        page_index,
  input  logic [4:0]        frame_number,
  input  logic [6:0]        num_pages,
  input  logic [6:0]        code_pages,
  input  logic [6:0]        data_pages,
  input  logic [6:0]        bss_pages,
  input  logic [12:0]       data_base_addr,
  input  logic [12:0]       bss_base_addr,
  output logic [5:0]        victim_page,
  output logic [5:0]        loaded_page,
  output logic [4:0]        frame_used,
  output logic [6:0]        page_offset,
  output logic [1:0]        write_back,
  output logic [1:0]        fill_source,
  output logic              bad_address
);
  import fpr_pkg::*;

  localparam int PW = $clog2(MAX_PAGES);
  localparam int RW = (RESIDENT_PAGES > 1) ? $clog2(RESIDENT_PAGES) : 1;
  localparam int OW = $clog2(PAGE_BYTES);
  localparam int FW = $clog2(FRAMES);
  localparam int XW = 16;  // page-number math width, covers all sums

  logic [MAX_PAGES-1:0] fwr_r;  // frame entry written since reset
  logic [MAX_PAGES-1:0] valid_r, used_r, dirty_r, swap_r;
  logic [PW-1:0] ring_r    [RESIDENT_PAGES];
  logic [RW-1:0] head_r;

  // captured beat and decode results
  logic [1:0]  op_r;
  logic [5:0]  pidx_r;
  logic [4:0]  frm_r;
  logic [XW-1:0] np_r;
  logic [6:0]  off_r;

  logic [5:0] victim_r;
  logic [5:0] loaded_r;
  logic [4:0] fused_r;
  logic [6:0] offo_r;
  logic [1:0] wb_r;
  logic [1:0] fill_r;
  logic       bad_r;

  // address split (stage 1)
  logic [XW-1:0] stack_pg, stack_start, a_ext, d_rel, b_rel, np_c;
  logic [XW-1:0] off_c;
  assign a_ext       = XW'(fault_address);
  assign stack_pg    = XW'(num_pages) - XW'(STACK_PAGES);
  assign stack_start = stack_pg * XW'(PAGE_BYTES);
  assign d_rel       = a_ext - XW'(data_base_addr);
  assign b_rel       = a_ext - XW'(bss_base_addr);

  always_comb begin
    np_c  = a_ext >> OW;
    off_c = a_ext & XW'(PAGE_BYTES - 1);
    // stack_start negative when num_pages < STACK_PAGES: address always above
    if ((XW'(num_pages) >= XW'(STACK_PAGES)) && (a_ext < stack_start)) begin
      if ((bss_pages != 7'd0) && (fault_address >= bss_base_addr)) begin
        np_c  = XW'(code_pages) + XW'(data_pages) + (b_rel >> OW);
        off_c = b_rel & XW'(PAGE_BYTES - 1);
      end else if ((data_pages != 7'd0) && (fault_address >= data_base_addr)) begin
        np_c  = XW'(code_pages) + (d_rel >> OW);
        off_c = d_rel & XW'(PAGE_BYTES - 1);
      end
    end
  end

  // page limit and segment lookup (stage 2)
  logic [XW-1:0] limit;
  assign limit = (XW'(num_pages) < XW'(MAX_PAGES)) ? XW'(num_pages) : XW'(MAX_PAGES);

  function automatic seg_t seg_of(input logic [XW-1:0] p, input logic [6:0] np,
                                  input logic [6:0] c, input logic [6:0] d,
                                  input logic [6:0] b);
    logic [XW-1:0] cd, cdb;
    logic signed [XW:0] sb;
    seg_t s;
    cd  = XW'(c) + XW'(d);
    cdb = cd + XW'(b);
    sb  = $signed({1'b0, XW'(np)}) - $signed((XW+1)'(STACK_PAGES));
    if (p < XW'(c))      s = SEG_CODE;
    else if (p < cd)     s = SEG_DATA;
    else if (p < cdb)    s = SEG_BSS;
    else if ($signed({1'b0, p}) >= sb) s = SEG_STACK;
    else                 s = SEG_NONE;
    return s;
  endfunction

  logic [PW-1:0] op_pg, np_pg;
  seg_t vs, ns;
  logic np_bad, idx_bad;
  assign op_pg   = ring_r[head_r];
  assign np_pg   = np_r[PW-1:0];
  assign np_bad  = (np_r >= limit);
  assign idx_bad = (XW'(pidx_r) >= limit);
  assign vs = seg_of(XW'(op_pg), num_pages, code_pages, data_pages, bss_pages);
  assign ns = seg_of(np_r, num_pages, code_pages, data_pages, bss_pages);

  // frame table: read address follows the ring head, so the victim's frame
  // is read out in the cycle after the ring last moved, well before the commit
  logic          fram_we;
  logic [PW-1:0] fram_waddr;
  logic [FW-1:0] fram_wdata, fram_q, vic_frame;
  assign vic_frame = fwr_r[op_pg] ? fram_q : '0;

  always_comb begin
    fram_we    = 1'b0;
    fram_waddr = np_pg;
    fram_wdata = vic_frame;
    if (cmd.commit) begin
      case (opcode_t'(op_r))
        OP_SET_FRAME: if (!idx_bad) begin
          fram_we    = 1'b1;
          fram_waddr = pidx_r[PW-1:0];
          fram_wdata = FW'(frm_r);
        end
        OP_FAULT: if (!np_bad) fram_we = 1'b1;
        default: ;
      endcase
    end
  end

  fpr_ram #(
    .WIDTH (FW),
    .DEPTH (MAX_PAGES)
  ) u_frame (
    .clk   (clk),
    .we    (fram_we),
    .waddr (fram_waddr),
    .wdata (fram_wdata),
    .raddr (op_pg),
    .rdata (fram_q)
  );

  logic vic_dirty, swap_after;
  assign vic_dirty  = dirty_r[op_pg];
  // in-swap of new page sees the victim's write-back when they coincide
  assign swap_after = (op_pg == np_pg && vic_dirty &&
                       (vs == SEG_BSS || vs == SEG_STACK)) ? 1'b1 : swap_r[np_pg];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwr_r   <= '0;
      valid_r <= '0;
      used_r  <= '0;
      dirty_r <= '0;
      swap_r  <= '0;
      head_r  <= '0;
      for (int i = 0; i < RESIDENT_PAGES; i++) ring_r[i] <= PW'(i % MAX_PAGES);
    end else if (cmd.commit) begin
      case (opcode_t'(op_r))
        OP_SET_FRAME: if (!idx_bad) begin
          fwr_r[pidx_r[PW-1:0]]   <= 1'b1;
          valid_r[pidx_r[PW-1:0]] <= 1'b1;
          used_r[pidx_r[PW-1:0]]  <= 1'b1;
        end
        OP_MARK: if (!idx_bad) dirty_r[pidx_r[PW-1:0]] <= 1'b1;
        OP_FAULT: if (!np_bad) begin
          ring_r[head_r] <= np_pg;
          head_r <= (head_r == RW'(RESIDENT_PAGES - 1)) ? '0 : head_r + 1'b1;
          fwr_r[np_pg]   <= 1'b1;
          valid_r[op_pg] <= 1'b0;
          dirty_r[op_pg] <= 1'b0;
          if (vic_dirty && (vs == SEG_BSS || vs == SEG_STACK)) swap_r[op_pg] <= 1'b1;
          valid_r[np_pg] <= 1'b1;
          used_r[np_pg]  <= 1'b1;
          dirty_r[np_pg] <= 1'b0;
          if ((ns == SEG_BSS || ns == SEG_STACK) && swap_after) swap_r[np_pg] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode;
      pidx_r <= page_index;
      frm_r  <= frame_number;
      np_r   <= np_c;
      off_r  <= off_c[6:0];
    end
    if (cmd.commit) begin
      victim_r <= '0;
      loaded_r <= '0;
      fused_r  <= '0;
      offo_r   <= '0;
      wb_r     <= WB_NONE;
      fill_r   <= FILL_NONE;
      bad_r    <= 1'b0;
      case (opcode_t'(op_r))
        OP_SET_FRAME, OP_MARK: bad_r <= idx_bad;
        OP_FAULT: begin
          offo_r <= off_r;
          if (np_bad) bad_r <= 1'b1;
          else begin
            victim_r <= 6'(op_pg);
            loaded_r <= 6'(np_pg);
            fused_r  <= 5'(vic_frame);
            if (vic_dirty) begin
              if (vs == SEG_CODE || vs == SEG_DATA) wb_r <= WB_EXEC;
              else if (vs == SEG_BSS || vs == SEG_STACK) wb_r <= WB_SWAP;
            end
            if (ns == SEG_CODE || ns == SEG_DATA) fill_r <= FILL_EXEC;
            else if (ns == SEG_BSS || ns == SEG_STACK)
              fill_r <= swap_after ? FILL_SWAP : FILL_ZERO;
          end
        end
        default: ;
      endcase
    end
  end

  assign victim_page = victim_r;
  assign loaded_page = loaded_r;
  assign frame_used  = fused_r;
  assign page_offset = offo_r;
  assign write_back  = wb_r;
  assign fill_source = fill_r;
  assign bad_address = bad_r;
endmodule

[rtl/fpr_checker.sv]
// fpr_checker: port-level assertions for fifo_page_replacement, bound in.
// Depends on fpr_stream_if.
`timescale 1ns / 1ps
module fpr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] fill_source,
  input logic [1:0] write_back,
  input logic bad_address
);
  // one item at a time: no input taken while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("accept while result pending");
  // an accepted beat yields a result once the commit state has passed
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 out_valid) else $error("result missing");
  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  // a bad address carries no write-back and no fill
  a_bad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && bad_address) |-> (write_back == 2'd0 && fill_source == 2'd3))
    else $error("bad address with side effects");
endmodule

bind fifo_page_replacement fpr_checker u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .fill_source (out_ch.data.fill_source),
  .write_back  (out_ch.data.write_back),
  .bad_address (out_ch.data.bad_address)
);
